@@ sv/round_robin_id_allocator_assert.svh @@
// Assertion macros for the identifier allocator.
// Both macros sample on clk and are switched off while rst is high.
`ifndef ROUND_ROBIN_ID_ALLOCATOR_ASSERT_SVH
`define ROUND_ROBIN_ID_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRIA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRIA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rria_pkg.sv @@
package rria_pkg;

  // Identifier range, capped to what fits the 10-bit fields
  localparam int MAX_IDS      = 1023;
  localparam int ID_LIMIT_INT = (MAX_IDS > 1023) ? 1023 : MAX_IDS;
  localparam int ID_W         = 10;

  // Bitmap held as words of 32 flags
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int MAP_WORDS = 32;
  localparam int WADDR_W   = 5;
  localparam int LAST_WORD = ID_LIMIT_INT / WORD_W;
  localparam int PASS_W    = 6;

  localparam logic [ID_W-1:0]    ID_LIMIT  = ID_W'(ID_LIMIT_INT);
  localparam logic [PASS_W-1:0]  LAST_PASS = PASS_W'(LAST_WORD + 1);
  localparam logic [WADDR_W-1:0] END_WORD  = WADDR_W'(MAP_WORDS - 1);

  // Command codes carried on tuser
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REL,
    S_SCAN,
    S_DONE
  } state_t;

  // Lowest set bit of a map word
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ sv/rria_ram.sv @@
module rria_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/round_robin_id_allocator.sv @@
// Round-robin identifier allocator.
// Input word (s_axis_*): tuser carries the command (0 acquire, 1 release),
// tdata carries the identifier to release. Output word (m_axis_*): tdata
// carries the granted identifier (0 if none) and a status (0 ok, 1 no free
// identifier, 2 invalid release). Every input word produces one output word.
// The active map lives in a 32 x 32-bit RAM with a registered read port.
// An acquire reads map words one per cycle starting at the word that holds the
// identifier after the last grant; the scan of up to 33 words is the limiting
// loop. An acquire passes through S_SCAN and S_DONE, a release through S_REL
// and S_DONE, and an invalid release goes straight to S_DONE, which loads the
// result into the output register. One item is in flight at a time: the next
// word is accepted only once the block is back in S_IDLE.
// After reset the block sweeps all 32 RAM words to zero with tready low.
// A finished result sits in the output register; while the receiver stalls,
// the next item is still accepted and worked on, and its result waits in the
// block until the output register frees up.
`include "round_robin_id_allocator_assert.svh"
module round_robin_id_allocator
  import rria_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] release_id, [15:10] zero
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [9:0] granted_id, [11:10] status, [15:12] zero
);

  state_t state, state_next;

  logic [WADDR_W-1:0] cur_word, cur_word_next;
  logic [PASS_W-1:0]  pass, pass_next;
  logic [ID_W-1:0]    start_id, start_id_next;
  logic [ID_W-1:0]    last_granted, last_granted_next;
  logic [ID_W-1:0]    rel_id, rel_id_next;
  logic [ID_W-1:0]    res_id, res_id_next;
  status_t            res_status, res_status_next;
  logic               out_valid_next;
  logic [15:0]        out_data_next;

  logic               ram_we;
  logic [WADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  logic               accept;
  logic               out_free;
  logic [ID_W-1:0]    rel_in;
  logic               rel_bad_in;
  logic [ID_W-1:0]    start_calc;
  logic [WADDR_W-1:0] next_word;
  logic [WORD_W-1:0]  range_mask;
  logic [WORD_W-1:0]  bound_mask;
  logic [WORD_W-1:0]  free_bits;
  logic               found;
  logic [BIT_W-1:0]   free_pos;

  rria_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign rel_in     = s_axis_tdata[ID_W-1:0];
  assign rel_bad_in = (rel_in == '0) || (rel_in > ID_LIMIT);
  assign start_calc = (last_granted < ID_LIMIT) ? last_granted + 1'b1 : ID_W'(1);
  assign next_word  = (cur_word == WADDR_W'(LAST_WORD)) ? '0 : cur_word + 1'b1;

  // Mark the flags of the current word that stand for identifiers in range
  always_comb begin
    logic [ID_W-1:0] probe_id;
    probe_id = '0;
    for (int b = 0; b < WORD_W; b++) begin
      probe_id      = {cur_word, BIT_W'(b)};
      range_mask[b] = (probe_id != '0) && (probe_id <= ID_LIMIT);
    end
  end

  // First pass starts at the start bit, the wrap pass stops before it
  always_comb begin
    if (pass == '0) begin
      bound_mask = {WORD_W{1'b1}} << start_id[BIT_W-1:0];
    end else if (pass == LAST_PASS) begin
      bound_mask = ~({WORD_W{1'b1}} << start_id[BIT_W-1:0]);
    end else begin
      bound_mask = {WORD_W{1'b1}};
    end
  end

  assign free_bits = ~ram_rdata & range_mask & bound_mask;
  assign found     = |free_bits;
  assign free_pos  = first_set(free_bits);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (cur_word == END_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser[0] == CMD_RELEASE) begin
            state_next = rel_bad_in ? S_DONE : S_REL;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_REL: state_next = S_DONE;
      S_SCAN: begin
        if (found || pass == LAST_PASS) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory access, result and register updates
  always_comb begin
    s_axis_tready     = (state == S_IDLE);
    ram_we            = 1'b0;
    ram_addr          = cur_word;
    ram_wdata         = '0;
    cur_word_next     = cur_word;
    pass_next         = pass;
    start_id_next     = start_id;
    last_granted_next = last_granted;
    rel_id_next       = rel_id;
    res_id_next       = res_id;
    res_status_next   = res_status;
    out_valid_next    = m_axis_tvalid && !m_axis_tready;
    out_data_next     = m_axis_tdata;
    case (state)
      S_CLEAR: begin
        // Sweep the map to all free
        ram_we        = 1'b1;
        cur_word_next = cur_word + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser[0] == CMD_RELEASE) begin
            rel_id_next     = rel_in;
            res_id_next     = '0;
            res_status_next = ST_BAD_RELEASE;
            ram_addr        = rel_in[ID_W-1:BIT_W];
          end else begin
            start_id_next = start_calc;
            ram_addr      = start_calc[ID_W-1:BIT_W];
            cur_word_next = start_calc[ID_W-1:BIT_W];
            pass_next     = '0;
          end
        end
      end
      S_REL: begin
        // Clear the flag of an active identifier, reject an inactive one
        res_id_next = '0;
        if (ram_rdata[rel_id[BIT_W-1:0]]) begin
          res_status_next = ST_OK;
          ram_we          = 1'b1;
          ram_addr        = rel_id[ID_W-1:BIT_W];
          ram_wdata       = ram_rdata & ~(WORD_W'(1) << rel_id[BIT_W-1:0]);
        end else begin
          res_status_next = ST_BAD_RELEASE;
        end
      end
      S_SCAN: begin
        if (found) begin
          // Grant the first free identifier and write the word back
          ram_we            = 1'b1;
          ram_wdata         = ram_rdata | (WORD_W'(1) << free_pos);
          last_granted_next = {cur_word, free_pos};
          res_id_next       = {cur_word, free_pos};
          res_status_next   = ST_OK;
        end else if (pass == LAST_PASS) begin
          res_id_next     = '0;
          res_status_next = ST_FULL;
        end else begin
          // Advance to the next word
          ram_addr      = next_word;
          cur_word_next = next_word;
          pass_next     = pass + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = {4'b0, res_status, res_id};
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cur_word      <= '0;
      pass          <= '0;
      last_granted  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      cur_word      <= cur_word_next;
      pass          <= pass_next;
      last_granted  <= last_granted_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    start_id     <= start_id_next;
    rel_id       <= rel_id_next;
    res_id       <= res_id_next;
    res_status   <= res_status_next;
    m_axis_tdata <= out_data_next;
  end

  `RRIA_ASSERT_IMP(a_fail_has_no_id, m_axis_tvalid && m_axis_tdata[11:10] != ST_OK, m_axis_tdata[9:0] == '0, "failed request carries an identifier")
  `RRIA_ASSERT_IMP(a_last_in_range, 1'b1, last_granted <= ID_LIMIT, "last grant out of range")
  `RRIA_ASSERT_NXT(a_grant_nonzero, state == S_SCAN && ram_we, last_granted != '0, "identifier zero granted")
  `RRIA_ASSERT_IMP(a_pass_bound, state == S_SCAN, pass <= LAST_PASS, "scan ran past the wrap pass")
  `RRIA_ASSERT_IMP(a_no_accept_clear, state == S_CLEAR, !s_axis_tready, "word accepted during clear")

endmodule
